// ----- sv/tfl_pkg.sv -----
// ---------------------------------------------------------------------------
// tfl_pkg: shared definitions for the translation buffer
// Field widths, operation codes, transfer payload types and parameter
// defaults used by the channel interface, the buffer and its checker.
// ---------------------------------------------------------------------------
package tfl_pkg;

    localparam int ENTRIES_DEFAULT    = 8;
    localparam int PAGE_BYTES_DEFAULT = 1024;

    localparam int ADDR_W      = 32;
    localparam int PROC_ID_W   = 8;
    localparam int VIRT_PAGE_W = 22;
    localparam int PHYS_PAGE_W = 12;
    localparam int OFFSET_W    = 10;

    typedef enum logic
    {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t                    op;
        logic [ADDR_W-1:0]      virt_address;
        logic [PROC_ID_W-1:0]   proc_id;
        logic [VIRT_PAGE_W-1:0] new_virt_page;
        logic [PHYS_PAGE_W-1:0] new_phys_page;
    } req_item_t;

    typedef struct packed
    {
        logic                   hit;
        logic [PHYS_PAGE_W-1:0] phys_page;
        logic [OFFSET_W-1:0]    page_offset;
    } resp_item_t;

endpackage

// ----- sv/tfl_chan_if.sv -----
// ---------------------------------------------------------------------------
// tfl_chan_if: valid/ready channel
// Carries one payload item per transfer; a transfer completes at a rising
// clock edge at which valid and ready are both high.
// ---------------------------------------------------------------------------
interface tfl_chan_if #(parameter type T = logic) ();

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ----- sv/tlb_fifo_lookup_insert.sv -----
// ---------------------------------------------------------------------------
// tlb_fifo_lookup_insert: fully associative translation buffer, FIFO refill
// Looks up or inserts one translation per transfer and returns one result
// per transfer.
// ---------------------------------------------------------------------------
// The buffer takes one request transfer in every clock cycle unless the
// response side stalls, and gives one response transfer per request, in
// request order, after it has passed the input register and then the
// result register. The rate is set by the single pass from the input
// register to the result register: the request's page number and process
// id are compared against every entry at once and the oldest matching
// entry is picked by a rotated priority encoder. A lookup returns hit, the
// physical page (zero on a miss) and the page offset; an insert returns
// all-zero fields. Inserts fill free slots in order and, once the buffer is
// full, replace the oldest entry. Entries are invalid after reset; no
// clearing pass is needed, so the buffer is ready at once.
// ---------------------------------------------------------------------------
module tlb_fifo_lookup_insert #(
    parameter int ENTRIES    = tfl_pkg::ENTRIES_DEFAULT,
    parameter int PAGE_BYTES = tfl_pkg::PAGE_BYTES_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    tfl_chan_if.sink       req,
    tfl_chan_if.source     resp
);

    import tfl_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int OFF_W = $clog2(PAGE_BYTES);

    // Input register stage.
    logic       s1_valid_reg;
    req_item_t  s1_item_reg;

    // Result register stage.
    logic       res_valid_reg;
    resp_item_t res_item_reg;
    resp_item_t res_item_next;

    // Entry storage: valid bits are reset, tags and pages are not.
    logic [ENTRIES-1:0]     entry_valid_reg;
    logic [VIRT_PAGE_W-1:0] entry_virt_page_reg [ENTRIES];
    logic [PROC_ID_W-1:0]   entry_proc_id_reg   [ENTRIES];
    logic [PHYS_PAGE_W-1:0] entry_phys_page_reg [ENTRIES];

    logic [CNT_W-1:0] fill_count_reg;
    logic [CNT_W-1:0] fill_count_next;
    logic [IDX_W-1:0] oldest_slot_reg;
    logic [IDX_W-1:0] oldest_slot_next;

    logic             res_load;
    logic             s1_load;
    logic             do_insert;
    logic [IDX_W-1:0] ins_slot;

    // The input stage moves on whenever the result register is empty or its
    // content is taken in this cycle; the input register refills behind it.
    assign res_load  = s1_valid_reg && (!res_valid_reg || resp.ready);
    assign req.ready = !s1_valid_reg || res_load;
    assign s1_load   = req.valid && req.ready;
    assign do_insert = res_load && (s1_item_reg.op == OP_INSERT);

    assign resp.valid = res_valid_reg;
    assign resp.data  = res_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (resp.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_item_reg <= req.data;
        end
        if (res_load)
        begin
            res_item_reg <= res_item_next;
        end
    end

    // Replacement bookkeeping: free slots are taken in order while the buffer
    // fills, after which the oldest slot is replaced and the age pointer
    // moves on, wrapping at the last slot.
    always_comb
    begin
        fill_count_next  = fill_count_reg;
        oldest_slot_next = oldest_slot_reg;
        if (fill_count_reg < CNT_W'(ENTRIES))
        begin
            ins_slot        = fill_count_reg[IDX_W-1:0];
            fill_count_next = fill_count_reg + CNT_W'(1);
        end
        else
        begin
            ins_slot = oldest_slot_reg;
            if (oldest_slot_reg == IDX_W'(ENTRIES - 1))
            begin
                oldest_slot_next = '0;
            end
            else
            begin
                oldest_slot_next = oldest_slot_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            fill_count_reg  <= '0;
            oldest_slot_reg <= '0;
        end
        else if (do_insert)
        begin
            entry_valid_reg[ins_slot] <= 1'b1;
            fill_count_reg            <= fill_count_next;
            oldest_slot_reg           <= oldest_slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_insert)
        begin
            entry_virt_page_reg[ins_slot] <= s1_item_reg.new_virt_page;
            entry_proc_id_reg[ins_slot]   <= s1_item_reg.proc_id;
            entry_phys_page_reg[ins_slot] <= s1_item_reg.new_phys_page;
        end
    end

    // Lookup. The page number is compared at the full address width, so a
    // page number wider than the stored tag never matches. Among matches, the
    // oldest wins: the lowest match at or above the age pointer, otherwise
    // the lowest match below it.
    logic [ADDR_W-1:0]  vpn_full;
    logic [ADDR_W-1:0]  off_full;
    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] match_upper;
    logic               hit_any;
    logic               hit_upper;
    logic [IDX_W-1:0]   idx_all;
    logic [IDX_W-1:0]   idx_upper;
    logic [IDX_W-1:0]   hit_idx;

    assign vpn_full = s1_item_reg.virt_address >> OFF_W;
    assign off_full = s1_item_reg.virt_address & ADDR_W'(PAGE_BYTES - 1);

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = entry_valid_reg[i]
                && (ADDR_W'(entry_virt_page_reg[i]) == vpn_full)
                && (entry_proc_id_reg[i] == s1_item_reg.proc_id);
            match_upper[i] = match[i] && (IDX_W'(i) >= oldest_slot_reg);
        end
    end

    always_comb
    begin
        idx_all   = '0;
        idx_upper = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                idx_all = IDX_W'(i);
            end
            if (match_upper[i])
            begin
                idx_upper = IDX_W'(i);
            end
        end
    end

    assign hit_any   = |match;
    assign hit_upper = |match_upper;
    assign hit_idx   = hit_upper ? idx_upper : idx_all;

    always_comb
    begin
        res_item_next = '0;
        if (s1_item_reg.op == OP_LOOKUP)
        begin
            res_item_next.hit         = hit_any;
            res_item_next.phys_page   = hit_any ? entry_phys_page_reg[hit_idx] : '0;
            res_item_next.page_offset = off_full[OFFSET_W-1:0];
        end
    end

endmodule

// ----- sv/tfl_checker.sv -----
// ---------------------------------------------------------------------------
// tfl_checker: port-level checks for the translation buffer
// Watches the request and response channels and flags protocol slips and
// result fields that the buffer must never produce.
// ---------------------------------------------------------------------------
module tfl_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                resp_valid,
    input logic                resp_ready,
    input tfl_pkg::resp_item_t resp_data
);

    import tfl_pkg::*;

    // A stalled response keeps its valid and its payload.
    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && !resp_ready |=> resp_valid && $stable(resp_data))
        else $error("response changed while stalled");

    // A response without a hit carries no physical page.
    a_miss_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && !resp_data.hit |-> resp_data.phys_page == '0)
        else $error("miss or insert response carries a page");

    // With the result register empty the buffer can always take a request.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !resp_valid |-> req_ready)
        else $error("request refused while no response is pending");

    // A request transfer is always answered by a response in a later cycle;
    // the response side cannot be empty while the pipe was loaded.
    a_resp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready ##1 req_ready |=> resp_valid || $past(resp_valid))
        else $error("request transfer not followed by a response");

endmodule

bind tlb_fifo_lookup_insert tfl_checker u_tfl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .resp_valid (resp.valid),
    .resp_ready (resp.ready),
    .resp_data  (resp.data)
);

// ----- test/tlb_fifo_lookup_insert_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlb_fifo_lookup_insert_checker: scoreboard for the translation buffer
// Watches both channels, keeps its own copy of the buffer contents, predicts
// the result of every request transfer and compares each response transfer
// with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module tlb_fifo_lookup_insert_checker #(
    parameter int ENTRIES    = tfl_pkg::ENTRIES_DEFAULT,
    parameter int PAGE_BYTES = tfl_pkg::PAGE_BYTES_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  tfl_pkg::req_item_t  req_data,
    input  logic                resp_valid,
    input  logic                resp_ready,
    input  tfl_pkg::resp_item_t resp_data,
    output int                  fail_count,
    output int                  pending
);

    import tfl_pkg::*;

    localparam int MAX_PRINTED = 40;

    logic                   slot_valid     [ENTRIES];
    logic [VIRT_PAGE_W-1:0] slot_virt_page [ENTRIES];
    logic [PROC_ID_W-1:0]   slot_proc_id   [ENTRIES];
    logic [PHYS_PAGE_W-1:0] slot_phys_page [ENTRIES];
    int                     slots_filled;
    int                     oldest_slot;
    resp_item_t             expected_results [$];
    int                     result_index;

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_PRINTED)
            $display("%t MISMATCH: %s", $realtime, msg);
        fail_count++;
    endtask

    // Applies one request to the shadow buffer and gives the result it causes.
    task automatic translate_request(input req_item_t item, output resp_item_t result);
        logic [ADDR_W-1:0] page_number;
        int                slot;
        result = '0;
        if (item.op == OP_INSERT)
        begin
            if (slots_filled < ENTRIES)
            begin
                slot = slots_filled;
                slots_filled++;
            end
            else
            begin
                slot        = oldest_slot;
                oldest_slot = (oldest_slot + 1) % ENTRIES;
            end
            slot_valid[slot]     = 1'b1;
            slot_virt_page[slot] = item.new_virt_page;
            slot_proc_id[slot]   = item.proc_id;
            slot_phys_page[slot] = item.new_phys_page;
        end
        else
        begin
            // The page number is compared at full address width.
            page_number        = item.virt_address / PAGE_BYTES;
            result.page_offset = OFFSET_W'(item.virt_address % PAGE_BYTES);
            for (int k = 0; k < ENTRIES; k++)
            begin
                slot = (oldest_slot + k) % ENTRIES;
                if (!result.hit && slot_valid[slot]
                    && ADDR_W'(slot_virt_page[slot]) == page_number
                    && slot_proc_id[slot] == item.proc_id)
                begin
                    result.hit       = 1'b1;
                    result.phys_page = slot_phys_page[slot];
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        resp_item_t predicted;
        resp_item_t wanted;
        if (!rst_n)
        begin
            for (int s = 0; s < ENTRIES; s++)
            begin
                slot_valid[s]     = 1'b0;
                slot_virt_page[s] = '0;
                slot_proc_id[s]   = '0;
                slot_phys_page[s] = '0;
            end
            slots_filled = 0;
            oldest_slot  = 0;
            result_index = 0;
            fail_count   = 0;
            expected_results.delete();
            pending <= 0;
        end
        else
        begin
            // The request is taken first so that any latency is handled.
            if (req_valid && req_ready)
            begin
                translate_request(req_data, predicted);
                expected_results = {expected_results, predicted};
            end
            if (resp_valid && resp_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with none outstanding",
                                              result_index));
                else
                begin
                    wanted = expected_results.pop_front();
                    if (resp_data.hit != wanted.hit
                        || resp_data.phys_page != wanted.phys_page
                        || resp_data.page_offset != wanted.page_offset)
                        report_mismatch($sformatf(
                            "result %0d: hit %0b page %h offset %h, expected %0b %h %h",
                            result_index, resp_data.hit, resp_data.phys_page,
                            resp_data.page_offset, wanted.hit, wanted.phys_page,
                            wanted.page_offset));
                end
                result_index++;
            end
            pending <= expected_results.size();
        end
    end

endmodule

// ----- test/tb_tlb_fifo_lookup_insert.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_tlb_fifo_lookup_insert: testbench for the translation buffer
// Drives a short directed sequence and then random lookups and inserts
// through several idling phases and one long response hold-off; the checker
// beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_tlb_fifo_lookup_insert;

    import tfl_pkg::*;

    localparam int ITEMS_PER_PHASE = 440;
    localparam int PRESSURE_ITEMS  = 80;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 10;
    localparam int RECENT_DEPTH    = 12;
    localparam int POOL_SIZE       = 6;
    localparam int RUN_LIMIT_NS    = 5_000_000;

    logic clk;
    logic rst_n;

    tfl_chan_if #(.T(req_item_t))  req ();
    tfl_chan_if #(.T(resp_item_t)) resp ();

    // Idling controls. The stimulus process owns them; the response side
    // only reads them.
    int send_idle_pct;
    int stall_pct;
    int hold_trigger;

    int fail_count;
    int pending;

    // Translations recently inserted by the random part, so that most
    // lookups aim at something that may still be in the buffer. The recent
    // list is longer than the buffer, so some of them have been evicted.
    logic [VIRT_PAGE_W-1:0] recent_page [RECENT_DEPTH];
    logic [PROC_ID_W-1:0]   recent_pid  [RECENT_DEPTH];
    int                     recent_count;

    // Small pools of tags for inserts, so that duplicates appear often.
    logic [VIRT_PAGE_W-1:0] page_pool [POOL_SIZE];
    logic [PROC_ID_W-1:0]   pid_pool  [POOL_SIZE];

    tlb_fifo_lookup_insert u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .resp  (resp)
    );

    tlb_fifo_lookup_insert_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_ready  (req.ready),
        .req_data   (req.data),
        .resp_valid (resp.valid),
        .resp_ready (resp.ready),
        .resp_data  (resp.data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A hard stop in case the block stops moving transfers altogether.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    // Response side. Ready is redrawn at every edge from the current stall
    // rate. When the stimulus bumps hold_trigger, ready is held low for a
    // long stretch that this process counts itself; the sender keeps
    // offering requests meanwhile, so the block fills and stalls its input.
    initial
    begin : resp_ready_drive
        int hold_left;
        int trigger_seen;
        hold_left    = 0;
        trigger_seen = 0;
        resp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_trigger != trigger_seen)
            begin
                trigger_seen = hold_trigger;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                resp.ready <= 1'b0;
            end
            else
                resp.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offers one request and returns at the edge where its transfer takes
    // place. Valid is only lowered when a gap follows, so back-to-back
    // requests never see valid dropped and raised within one time step.
    task automatic send_request(input req_item_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= item;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    // The fields that an operation ignores still carry random values, so
    // that the block is seen to ignore them.
    function automatic req_item_t lookup_item(input logic [ADDR_W-1:0] addr,
                                              input logic [PROC_ID_W-1:0] pid);
        req_item_t item;
        item.op            = OP_LOOKUP;
        item.virt_address  = addr;
        item.proc_id       = pid;
        item.new_virt_page = VIRT_PAGE_W'($urandom);
        item.new_phys_page = PHYS_PAGE_W'($urandom);
        return item;
    endfunction

    function automatic req_item_t insert_item(input logic [VIRT_PAGE_W-1:0] vpage,
                                              input logic [PROC_ID_W-1:0] pid,
                                              input logic [PHYS_PAGE_W-1:0] ppage);
        req_item_t item;
        item.op            = OP_INSERT;
        item.virt_address  = $urandom;
        item.proc_id       = pid;
        item.new_virt_page = vpage;
        item.new_phys_page = ppage;
        return item;
    endfunction

    // Directed part: empty-buffer misses, the field extremes, a hit, a miss
    // on process id alone, a duplicate insert where the older entry must
    // answer, filling the buffer and then evicting in FIFO order.
    task automatic run_directed();
        send_request(lookup_item(32'h0000_0000, 8'h00));
        send_request(lookup_item(32'hFFFF_FFFF, 8'hFF));
        send_request(insert_item(22'h000000, 8'h00, 12'h000));
        send_request(insert_item(22'h3FFFFF, 8'hFF, 12'hFFF));
        send_request(lookup_item(32'h0000_03FF, 8'h00));
        send_request(lookup_item(32'hFFFF_FFFF, 8'hFF));
        send_request(lookup_item(32'hFFFF_FC00, 8'hFE));
        send_request(lookup_item(32'h0000_0400, 8'h00));
        // A second translation for page zero: the first one is older and wins.
        send_request(insert_item(22'h000000, 8'h00, 12'hABC));
        send_request(lookup_item(32'h0000_0123, 8'h00));
        for (int k = 0; k < 5; k++)
            send_request(insert_item(VIRT_PAGE_W'(16 + k), PROC_ID_W'(k),
                                     PHYS_PAGE_W'(256 + k)));
        // The buffer is full now; this insert replaces the very first entry,
        // leaving the duplicate to answer for page zero.
        send_request(insert_item(22'h2AAAAA, 8'h55, 12'h555));
        send_request(lookup_item(32'h0000_0001, 8'h00));
        send_request(insert_item(22'h155555, 8'hAA, 12'hAAA));
        send_request(lookup_item(32'hFFFF_FFFF, 8'hFF));
        send_request(lookup_item({22'h2AAAAA, 10'h155}, 8'h55));
        send_request(lookup_item({22'h155555, 10'h2AA}, 8'hAA));
        send_request(lookup_item($urandom, PROC_ID_W'($urandom)));
    endtask

    // Random part. About a third are inserts, mostly from the small tag
    // pools; most lookups aim at a recent insert, now and then with one
    // process id bit flipped; the rest are random noise.
    task automatic pick_random_request(output req_item_t item);
        int roll;
        int idx;
        int span;
        item = lookup_item($urandom, PROC_ID_W'($urandom));
        roll = $urandom_range(99);
        if (roll < 35)
        begin
            item.op            = OP_INSERT;
            item.new_virt_page = VIRT_PAGE_W'($urandom);
            item.new_phys_page = PHYS_PAGE_W'($urandom);
            if ($urandom_range(3) != 0)
            begin
                item.new_virt_page = page_pool[$urandom_range(POOL_SIZE - 1)];
                item.proc_id       = pid_pool[$urandom_range(POOL_SIZE - 1)];
            end
            recent_page[recent_count % RECENT_DEPTH] = item.new_virt_page;
            recent_pid[recent_count % RECENT_DEPTH]  = item.proc_id;
            recent_count++;
        end
        else if (roll < 85 && recent_count > 0)
        begin
            span = (recent_count < RECENT_DEPTH) ? recent_count : RECENT_DEPTH;
            idx  = $urandom_range(span - 1);
            item.virt_address = {recent_page[idx], OFFSET_W'($urandom)};
            item.proc_id      = recent_pid[idx];
            if ($urandom_range(9) == 0)
                item.proc_id = item.proc_id ^ PROC_ID_W'(1 << $urandom_range(7));
        end
    endtask

    initial
    begin : stimulus
        req_item_t item;
        // Every input of the block is known from time zero; reset is taken
        // once here and then released.
        req.valid     <= 1'b0;
        req.data      <= '0;
        rst_n         <= 1'b0;
        stall_pct     <= 0;
        hold_trigger  <= 0;
        send_idle_pct = 0;
        recent_count  = 0;
        page_pool[0]  = '0;
        page_pool[1]  = '1;
        pid_pool[0]   = '0;
        pid_pool[1]   = '1;
        for (int p = 2; p < POOL_SIZE; p++)
        begin
            page_pool[p] = VIRT_PAGE_W'($urandom);
            pid_pool[p]  = PROC_ID_W'($urandom);
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // Four idling phases: none, sender mostly idle, receiver mostly
        // stalling, and both idling now and then.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 82; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 82; end
                default: begin send_idle_pct = 24; stall_pct <= 24; end
            endcase
            repeat (ITEMS_PER_PHASE)
            begin
                pick_random_request(item);
                send_request(item);
            end
        end

        // Back-pressure: the receiver holds off for a long stretch while
        // requests are offered at full rate.
        send_idle_pct = 0;
        stall_pct    <= 0;
        hold_trigger <= hold_trigger + 1;
        repeat (PRESSURE_ITEMS)
        begin
            pick_random_request(item);
            send_request(item);
        end
        req.valid <= 1'b0;

        // Let every outstanding result arrive, then wait out DRAIN_CYCLES for
        // anything unexpected to show itself.
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
sv/tfl_pkg.sv
sv/tfl_chan_if.sv
sv/tlb_fifo_lookup_insert.sv
sv/tfl_checker.sv
test/tlb_fifo_lookup_insert_checker.sv
test/tb_tlb_fifo_lookup_insert.sv
